[hw/rtl/dscpq_pkg.sv]
// Shared types, constants and field layouts for the DSCP strict-priority queue.
package dscpq_pkg;

    // Default sizing of the queue.
    localparam int DEF_MAX_BANDS  = 8;
    localparam int DEF_BAND_DEPTH = 64;

    // Field widths.
    localparam int FUNC_W   = 2;
    localparam int DSCP_W   = 6;
    localparam int PORT_W   = 16;
    localparam int TAG_W    = 16;
    localparam int BAND_W   = 3;
    localparam int BCOUNT_W = 4;
    localparam int ENTRY_W  = DSCP_W + TAG_W;

    // Stream and configuration port widths.
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = FUNC_W;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 1;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 23;

    localparam int NUM_RULES = 3;

    localparam logic [DSCP_W-1:0] DSCP_REMARK = 6'd22;
    localparam logic [DSCP_W-1:0] DSCP_EF     = 6'd46;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_RULE_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_RULE_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_RULE_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_RULE_0 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_RULE_1 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_RULE_2 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_COUNT  = 3'd6;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ENQ  = 2'd0,
        FUNC_DEQ  = 2'd1,
        FUNC_PEEK = 2'd2
    } t_func;

    typedef struct packed {
        logic              valid;
        logic [DSCP_W-1:0] dscp;
        logic [BAND_W-1:0] band;
    } t_band_rule;

    typedef struct packed {
        logic              valid;
        logic [PORT_W-1:0] port;
        logic [DSCP_W-1:0] dscp;
    } t_port_rule;

    typedef struct packed {
        logic [DSCP_W-1:0] dscp;
        logic [BAND_W-1:0] band;
    } t_class_res;

    localparam t_band_rule BAND_RULE_0_RST = 10'd522;
    localparam t_band_rule BAND_RULE_1_RST = 10'd532;
    localparam t_band_rule BAND_RULE_2_RST = 10'd0;
    localparam t_port_rule PORT_RULE_0_RST = 23'd4711470;
    localparam t_port_rule PORT_RULE_1_RST = 23'd4711492;
    localparam t_port_rule PORT_RULE_2_RST = 23'd0;
    localparam logic [BCOUNT_W-1:0] BAND_COUNT_RST = 4'd2;

endpackage

[hw/rtl/dscpq_ram.sv]
// Generic simple dual-port RAM with registered read data.
module dscpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/dscpq_classify.sv]
// DSCP remarking by UDP port and DSCP-to-band classification for enqueues.
module dscpq_classify
    import dscpq_pkg::*;
#(
    parameter int CW = 4
) (
    input  t_band_rule [NUM_RULES-1:0] i_band_rules,
    input  t_port_rule [NUM_RULES-1:0] i_port_rules,
    input  logic [DSCP_W-1:0]          i_dscp,
    input  logic [PORT_W-1:0]          i_port,
    input  logic [CW-1:0]              i_active,
    output t_class_res                 o_res
);

    logic [DSCP_W-1:0] remarked;
    logic [DSCP_W-1:0] dscp;
    logic [BAND_W-1:0] band;

    always_comb begin
        // Walk the rules downward so the lowest-numbered match wins.
        remarked = DSCP_EF;
        for (int r = NUM_RULES - 1; r >= 0; r--) begin
            if (i_port_rules[r].valid && i_port_rules[r].port == i_port) begin
                remarked = i_port_rules[r].dscp;
            end
        end
        dscp = (i_dscp == DSCP_REMARK) ? remarked : i_dscp;

        band = '0;
        for (int r = NUM_RULES - 1; r >= 0; r--) begin
            if (i_band_rules[r].valid && i_band_rules[r].dscp == dscp) begin
                band = i_band_rules[r].band;
            end
        end
        if (CW'(band) >= i_active) begin
            band = BAND_W'(i_active - CW'(1));
        end

        o_res.dscp = dscp;
        o_res.band = band;
    end

endmodule

[hw/rtl/dscp_strict_priority_queue.sv]
// Top level of the DSCP-classifying strict-priority descriptor queue.
//
// Usage: each transfer on the slave stream is one operation, selected by
// s_tuser: enqueue, dequeue or peek. An enqueue carries a DSCP, a UDP
// destination port and a packet tag; a DSCP of 22 is remarked through the
// port rules, then the band rules pick a band, clamped to the active bands.
// Each band is a drop-tail FIFO of BAND_DEPTH descriptors held in one RAM.
// Dequeue and peek serve the lowest-numbered non-empty active band.
// Every operation gives exactly one result transfer on the master stream.
//
// An accepted operation waits in the input register, where classification,
// band search and pointer update happen; when it advances, the result stage
// is loaded along with the registered RAM read. Throughput is one operation
// per cycle while the receiver keeps up. When the receiver stalls, the
// result stage holds and the input register fills; s_tready then drops
// until the result is taken. Configuration writes are always ready; the
// user must issue them only while the queue is idle, and the block itself
// does not enforce this. Reset clears all band pointers and fill levels and
// loads the rule defaults; the descriptor RAM needs no clearing, since only
// written entries are ever read.
module dscp_strict_priority_queue
    import dscpq_pkg::*;
#(
    parameter int MAX_BANDS  = DEF_MAX_BANDS,
    parameter int BAND_DEPTH = DEF_BAND_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Slave stream: tdata = dscp[5:0], dest_port[21:6], packet_tag[37:22], zero pad.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    // tuser = func[1:0].
    input  logic [S_TUSER_W-1:0] s_tuser,
    // Master stream: tdata = band[2:0], out_dscp[8:3], out_tag[24:9], zero pad.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    // tuser = ok[0].
    output logic [M_TUSER_W-1:0] m_tuser,
    // Configuration write channel.
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    localparam int BW        = $clog2(MAX_BANDS);
    localparam int IW        = $clog2(BAND_DEPTH);
    localparam int FW        = $clog2(BAND_DEPTH + 1);
    localparam int NW        = $clog2(MAX_BANDS + 1);
    localparam int CW        = (NW > BCOUNT_W) ? NW : BCOUNT_W;
    localparam int RAM_DEPTH = MAX_BANDS * (2 ** IW);
    localparam int AW        = BW + IW;

    // Configuration registers.
    t_band_rule [NUM_RULES-1:0] r_band_rules;
    t_port_rule [NUM_RULES-1:0] r_port_rules;
    logic [BCOUNT_W-1:0]        r_band_count;

    // Per-band FIFO state.
    logic [IW-1:0] r_head [MAX_BANDS];
    logic [IW-1:0] r_tail [MAX_BANDS];
    logic [FW-1:0] r_fill [MAX_BANDS];

    // Input register.
    logic              r_s1_valid;
    logic [FUNC_W-1:0] r_s1_func;
    logic [DSCP_W-1:0] r_s1_dscp;
    logic [PORT_W-1:0] r_s1_port;
    logic [TAG_W-1:0]  r_s1_tag;

    // Result stage.
    logic              r_s2_valid;
    logic              r_s2_ok;
    logic              r_s2_from_ram;
    logic [BAND_W-1:0] r_s2_band;
    logic [DSCP_W-1:0] r_s2_dscp;

    logic               s1_adv;
    logic [CW-1:0]      active;
    t_class_res         cls;
    logic [BW-1:0]      enq_band;
    logic               enq_full;
    logic               srch_hit;
    logic [BW-1:0]      srch_band;
    logic               do_enq;
    logic               do_read;
    logic               do_pop;
    logic               n_ok;
    logic               n_from_ram;
    logic [BAND_W-1:0]  n_band;
    logic [DSCP_W-1:0]  n_dscp;
    logic [ENTRY_W-1:0] ram_rdata;

    assign o_cfg_ready = 1'b1;

    // Configuration writes; an index beyond the list is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band_rules[0] <= BAND_RULE_0_RST;
            r_band_rules[1] <= BAND_RULE_1_RST;
            r_band_rules[2] <= BAND_RULE_2_RST;
            r_port_rules[0] <= PORT_RULE_0_RST;
            r_port_rules[1] <= PORT_RULE_1_RST;
            r_port_rules[2] <= PORT_RULE_2_RST;
            r_band_count    <= BAND_COUNT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BAND_RULE_0: r_band_rules[0] <= i_cfg_data[$bits(t_band_rule)-1:0];
                CFG_BAND_RULE_1: r_band_rules[1] <= i_cfg_data[$bits(t_band_rule)-1:0];
                CFG_BAND_RULE_2: r_band_rules[2] <= i_cfg_data[$bits(t_band_rule)-1:0];
                CFG_PORT_RULE_0: r_port_rules[0] <= i_cfg_data[$bits(t_port_rule)-1:0];
                CFG_PORT_RULE_1: r_port_rules[1] <= i_cfg_data[$bits(t_port_rule)-1:0];
                CFG_PORT_RULE_2: r_port_rules[2] <= i_cfg_data[$bits(t_port_rule)-1:0];
                CFG_BAND_COUNT:  r_band_count    <= i_cfg_data[BCOUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Active band count: the programmed count clamped to [2, MAX_BANDS].
    always_comb begin
        active = CW'(r_band_count);
        if (active < CW'(2)) begin
            active = CW'(2);
        end else if (active > CW'(MAX_BANDS)) begin
            active = CW'(MAX_BANDS);
        end
    end

    // The input register moves on whenever the result stage is free or drains.
    assign s1_adv   = r_s1_valid && (!r_s2_valid || m_tready);
    assign s_tready = !r_s1_valid || s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_tready) begin
            r_s1_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_s1_func <= s_tuser[FUNC_W-1:0];
            r_s1_dscp <= s_tdata[DSCP_W-1:0];
            r_s1_port <= s_tdata[DSCP_W +: PORT_W];
            r_s1_tag  <= s_tdata[DSCP_W + PORT_W +: TAG_W];
        end
    end

    dscpq_classify #(
        .CW(CW)
    ) u_classify (
        .i_band_rules(r_band_rules),
        .i_port_rules(r_port_rules),
        .i_dscp      (r_s1_dscp),
        .i_port      (r_s1_port),
        .i_active    (active),
        .o_res       (cls)
    );

    assign enq_band = BW'(cls.band);
    assign enq_full = (r_fill[enq_band] == FW'(BAND_DEPTH));

    // Lowest-numbered non-empty active band.
    always_comb begin
        srch_hit  = 1'b0;
        srch_band = '0;
        for (int b = MAX_BANDS - 1; b >= 0; b--) begin
            if (CW'(b) < active && r_fill[b] != '0) begin
                srch_hit  = 1'b1;
                srch_band = BW'(b);
            end
        end
    end

    always_comb begin
        do_enq     = 1'b0;
        do_read    = 1'b0;
        do_pop     = 1'b0;
        n_ok       = 1'b0;
        n_from_ram = 1'b0;
        n_band     = '0;
        n_dscp     = '0;
        unique case (t_func'(r_s1_func))
            FUNC_ENQ: begin
                do_enq = !enq_full;
                n_ok   = !enq_full;
                n_band = cls.band;
                n_dscp = cls.dscp;
            end
            FUNC_DEQ, FUNC_PEEK: begin
                do_read    = srch_hit;
                do_pop     = srch_hit && (t_func'(r_s1_func) == FUNC_DEQ);
                n_ok       = srch_hit;
                n_from_ram = srch_hit;
                n_band     = srch_hit ? BAND_W'(srch_band) : '0;
            end
            default: ;
        endcase
    end

    // Pointer and fill updates commit when the operation leaves the input register,
    // the same edge that writes or reads the RAM.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < MAX_BANDS; b++) begin
                r_head[b] <= '0;
                r_tail[b] <= '0;
                r_fill[b] <= '0;
            end
        end else if (s1_adv) begin
            if (do_enq) begin
                r_tail[enq_band] <= (r_tail[enq_band] == IW'(BAND_DEPTH - 1)) ?
                                    '0 : r_tail[enq_band] + IW'(1);
                r_fill[enq_band] <= r_fill[enq_band] + FW'(1);
            end
            if (do_pop) begin
                r_head[srch_band] <= (r_head[srch_band] == IW'(BAND_DEPTH - 1)) ?
                                     '0 : r_head[srch_band] + IW'(1);
                r_fill[srch_band] <= r_fill[srch_band] - FW'(1);
            end
        end
    end

    // An operation is either a write or a read, so the RAM never sees both at once.
    dscpq_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(RAM_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (s1_adv && do_enq),
        .i_waddr(AW'({enq_band, r_tail[enq_band]})),
        .i_wdata({cls.dscp, r_s1_tag}),
        .i_re   (s1_adv && do_read),
        .i_raddr(AW'({srch_band, r_head[srch_band]})),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s1_adv) begin
            r_s2_valid <= 1'b1;
        end else if (m_tready) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s2_ok       <= n_ok;
            r_s2_from_ram <= n_from_ram;
            r_s2_band     <= n_band;
            r_s2_dscp     <= n_dscp;
        end
    end

    // The RAM read register holds until the next read, which only comes
    // once this result has been taken.
    assign m_tvalid = r_s2_valid;
    assign m_tuser  = r_s2_ok;
    assign m_tdata  = M_TDATA_W'({
        r_s2_from_ram ? ram_rdata[TAG_W-1:0] : {TAG_W{1'b0}},
        r_s2_from_ram ? ram_rdata[TAG_W +: DSCP_W] : r_s2_dscp,
        r_s2_band
    });

endmodule

[hw/rtl/dscpq_checker.sv]
// Port-level checker for the DSCP strict-priority queue, with its bind.
module dscpq_checker
    import dscpq_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [M_TUSER_W-1:0] m_tuser,
    input logic                 i_cfg_valid,
    input logic                 o_cfg_ready
);

    // A stalled result keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // A failed operation never carries a tag.
    a_fail_no_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[24:9] == '0)
        else $error("failed result carries a tag");

    // No result right after reset.
    a_reset_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !m_tvalid)
        else $error("result right after reset");

    // An input stall only happens while a result is stalled.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");

    // The configuration channel never stalls.
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("configuration write stalled");

endmodule

bind dscp_strict_priority_queue dscpq_checker u_dscpq_checker (.*);

[tb/dscp_strict_priority_queue_tb.sv]
// Self-checking testbench for the DSCP-classifying strict-priority descriptor queue.
module dscp_strict_priority_queue_tb;
    import dscpq_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int CLK_PERIOD   = 2 * CLK_HALF;
    localparam int LIMIT_CYCLES = 400_000;
    localparam int MAX_BANDS    = DEF_MAX_BANDS;
    localparam int BAND_DEPTH   = DEF_BAND_DEPTH;
    localparam int MAX_REPORTS  = 10;
    // The pipeline is two stages deep; the settle time adds margin for any slack.
    localparam int SETTLE_CYCLES = 6;

    // The fourth operation code is unused by the block; it must leave the
    // queue untouched and answer with an all-zero result.
    localparam logic [FUNC_W-1:0]    FUNC_NONE  = 2'd3;
    // Index seven addresses no register, so a write there must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;

    // One result transfer, unpacked into its fields.
    typedef struct packed {
        logic              ok;
        logic [BAND_W-1:0] band;
        logic [DSCP_W-1:0] dscp;
        logic [TAG_W-1:0]  tag;
    } t_queue_result;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;
    logic [S_TUSER_W-1:0] s_tuser     = '0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data  = '0;

    dscp_strict_priority_queue i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Shadow copy of the rule tables and the band count, updated on every
    // configuration transfer.
    t_band_rule          band_rule_q [NUM_RULES];
    t_port_rule          port_rule_q [NUM_RULES];
    logic [BCOUNT_W-1:0] band_count_q;

    // Shadow copy of the per-band descriptor rings.
    logic [ENTRY_W-1:0] ring_store [MAX_BANDS][BAND_DEPTH];
    int                 ring_head  [MAX_BANDS];
    int                 ring_tail  [MAX_BANDS];
    int                 ring_fill  [MAX_BANDS];

    // Results predicted for accepted operations, oldest first.
    t_queue_result expected_results[$];

    // Idling controls for both sides of the stream.
    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;
    int rx_stall_left = 0;

    int error_count   = 0;
    int checked_count = 0;
    int op_count      = 0;
    int enq_stored    = 0;
    int enq_dropped   = 0;
    int remark_count  = 0;
    int served_count  = 0;
    int empty_count   = 0;
    int cfg_writes    = 0;

    // Work out the result of one operation and advance the shadow queue. The
    // DSCP of 22 is remarked through the port rules (lowest matching rule
    // wins, else EF) and is never remarked twice; the band rules then pick a
    // band, which is clamped to the last active band.
    function automatic t_queue_result predict_queue_op(
        input logic [FUNC_W-1:0] func,
        input logic [DSCP_W-1:0] dscp,
        input logic [PORT_W-1:0] port,
        input logic [TAG_W-1:0]  tag
    );
        t_queue_result     res;
        logic [DSCP_W-1:0] new_dscp;
        logic [BAND_W-1:0] band;
        logic              hit;
        int                active;
        res    = '0;
        active = (band_count_q < 2) ? 2 :
                 (band_count_q > MAX_BANDS) ? MAX_BANDS : int'(band_count_q);
        if (func == FUNC_ENQ) begin
            new_dscp = dscp;
            if (dscp == DSCP_REMARK) begin
                new_dscp = DSCP_EF;
                hit      = 1'b0;
                for (int r = 0; r < NUM_RULES; r++) begin
                    if (!hit && port_rule_q[r].valid && port_rule_q[r].port == port) begin
                        new_dscp = port_rule_q[r].dscp;
                        hit      = 1'b1;
                    end
                end
                remark_count++;
            end
            band = '0;
            hit  = 1'b0;
            for (int r = 0; r < NUM_RULES; r++) begin
                if (!hit && band_rule_q[r].valid && band_rule_q[r].dscp == new_dscp) begin
                    band = band_rule_q[r].band;
                    hit  = 1'b1;
                end
            end
            if (band >= active) band = BAND_W'(active - 1);
            res.band = band;
            res.dscp = new_dscp;
            if (ring_fill[band] < BAND_DEPTH) begin
                ring_store[band][ring_tail[band]] = {new_dscp, tag};
                ring_tail[band] = (ring_tail[band] + 1) % BAND_DEPTH;
                ring_fill[band]++;
                res.ok = 1'b1;
                enq_stored++;
            end else begin
                enq_dropped++;
            end
        end else if (func == FUNC_DEQ || func == FUNC_PEEK) begin
            for (int b = 0; b < active; b++) begin
                if (!res.ok && ring_fill[b] != 0) begin
                    res.ok               = 1'b1;
                    res.band             = BAND_W'(b);
                    {res.dscp, res.tag}  = ring_store[b][ring_head[b]];
                    if (func == FUNC_DEQ) begin
                        ring_head[b] = (ring_head[b] + 1) % BAND_DEPTH;
                        ring_fill[b]--;
                    end
                end
            end
            if (res.ok) served_count++;
            else        empty_count++;
        end
        return res;
    endfunction

    function automatic int queued_total();
        int sum;
        sum = 0;
        for (int b = 0; b < MAX_BANDS; b++) sum += ring_fill[b];
        return sum;
    endfunction

    // DSCP values are drawn so that the remark trigger and the DSCPs named
    // in the band rules come up often.
    function automatic logic [DSCP_W-1:0] pick_dscp();
        case ($urandom_range(0, 9))
            0, 1, 2: return DSCP_REMARK;
            3, 4, 5: return band_rule_q[$urandom_range(0, NUM_RULES - 1)].dscp;
            default: return DSCP_W'($urandom);
        endcase
    endfunction

    function automatic logic [PORT_W-1:0] pick_port();
        if ($urandom_range(0, 1)) return port_rule_q[$urandom_range(0, NUM_RULES - 1)].port;
        return PORT_W'($urandom);
    endfunction

    // Drive one operation onto the slave stream and wait for its transfer.
    // The task is entered and left at a rising edge. A random burst of idle
    // cycles may precede the operation.
    task automatic send_op(
        input logic [FUNC_W-1:0] func,
        input logic [DSCP_W-1:0] dscp,
        input logic [PORT_W-1:0] port,
        input logic [TAG_W-1:0]  tag
    );
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {{(S_TDATA_W - TAG_W - PORT_W - DSCP_W){1'b0}}, tag, port, dscp};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        expected_results.push_back(predict_queue_op(func, dscp, port, tag));
        op_count++;
    endtask

    task automatic send_random_op(input int enq_pct);
        int                r;
        logic [FUNC_W-1:0] func;
        r = $urandom_range(0, 99);
        if (r < 2)                        func = FUNC_NONE;
        else if (r < enq_pct)             func = FUNC_ENQ;
        else if ($urandom_range(0, 3) == 0) func = FUNC_PEEK;
        else                              func = FUNC_DEQ;
        send_op(func, pick_dscp(), pick_port(), TAG_W'($urandom));
    endtask

    // Stop sending and let every outstanding result drain, so the block is
    // idle before registers change.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One configuration transfer. The valid is dropped after each transfer
    // so that back-to-back writes never clash in one step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_BAND_RULE_0: band_rule_q[0] = data[$bits(t_band_rule)-1:0];
            CFG_BAND_RULE_1: band_rule_q[1] = data[$bits(t_band_rule)-1:0];
            CFG_BAND_RULE_2: band_rule_q[2] = data[$bits(t_band_rule)-1:0];
            CFG_PORT_RULE_0: port_rule_q[0] = data[$bits(t_port_rule)-1:0];
            CFG_PORT_RULE_1: port_rule_q[1] = data[$bits(t_port_rule)-1:0];
            CFG_PORT_RULE_2: port_rule_q[2] = data[$bits(t_port_rule)-1:0];
            CFG_BAND_COUNT:  band_count_q   = data[BCOUNT_W-1:0];
            default: ;
        endcase
        cfg_writes++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Load random rule tables. The band count often lands on its extremes,
    // including the values below two and above the number of bands.
    task automatic randomize_rules();
        t_band_rule          br;
        t_port_rule          pr;
        logic [BCOUNT_W-1:0] cnt;
        for (int r = 0; r < NUM_RULES; r++) begin
            br.valid = ($urandom_range(0, 4) != 0);
            case ($urandom_range(0, 3))
                0:       br.dscp = DSCP_REMARK;
                1:       br.dscp = DSCP_EF;
                default: br.dscp = DSCP_W'($urandom);
            endcase
            br.band = BAND_W'($urandom);
            write_reg(CFG_IDX_W'(CFG_BAND_RULE_0 + r), CFG_DAT_W'(br));
        end
        for (int r = 0; r < NUM_RULES; r++) begin
            pr.valid = ($urandom_range(0, 4) != 0);
            pr.port  = ($urandom_range(0, 3) == 0) ? {PORT_W{1'b1}} : PORT_W'($urandom);
            pr.dscp  = ($urandom_range(0, 3) == 0) ? DSCP_REMARK : DSCP_W'($urandom);
            write_reg(CFG_IDX_W'(CFG_PORT_RULE_0 + r), pr);
        end
        case ($urandom_range(0, 5))
            0:       cnt = 4'd0;
            1:       cnt = 4'd15;
            2:       cnt = 4'd8;
            3:       cnt = 4'd2;
            default: cnt = BCOUNT_W'($urandom);
        endcase
        write_reg(CFG_BAND_COUNT, CFG_DAT_W'(cnt));
        if ($urandom_range(0, 3) == 0) write_reg(CFG_NO_REG, CFG_DAT_W'($urandom));
    endtask

    // Reset defaults: empty-queue answers, the unused operation, remarking
    // through the default port rules and clamping of bands two and four.
    task automatic test_reset_defaults();
        send_op(FUNC_PEEK, '0, '0, '0);
        send_op(FUNC_DEQ, '1, '1, '1);
        send_op(FUNC_NONE, '1, '1, '1);
        send_op(FUNC_ENQ, 6'd1, '0, '0);
        send_op(FUNC_ENQ, 6'd2, 16'd1234, '1);
        send_op(FUNC_ENQ, DSCP_REMARK, 16'd8080, 16'h1111);
        send_op(FUNC_ENQ, DSCP_REMARK, 16'd8081, 16'h2222);
        send_op(FUNC_ENQ, DSCP_REMARK, 16'd0, 16'h3333);
        send_op(FUNC_ENQ, '1, '1, '1);
        send_op(FUNC_PEEK, '0, '0, '0);
        repeat (7) send_op(FUNC_DEQ, '0, '0, '0);
    endtask

    // Rule priority, a remark to 22 that is not remarked again, the ignored
    // register index, and band counts lowered and raised around waiting
    // packets.
    task automatic test_rule_tables();
        wait_idle();
        write_reg(CFG_BAND_COUNT, CFG_DAT_W'(4'd8));
        write_reg(CFG_BAND_RULE_0,
                  CFG_DAT_W'(t_band_rule'{valid: 1'b1, dscp: DSCP_EF, band: 3'd6}));
        write_reg(CFG_BAND_RULE_1,
                  CFG_DAT_W'(t_band_rule'{valid: 1'b1, dscp: DSCP_REMARK, band: 3'd3}));
        write_reg(CFG_BAND_RULE_2, '1);
        write_reg(CFG_PORT_RULE_0, t_port_rule'{valid: 1'b1, port: 16'd5000, dscp: DSCP_REMARK});
        write_reg(CFG_PORT_RULE_1, t_port_rule'{valid: 1'b1, port: 16'd5000, dscp: 6'd10});
        write_reg(CFG_PORT_RULE_2, '1);
        write_reg(CFG_NO_REG, '1);
        send_op(FUNC_ENQ, DSCP_REMARK, 16'd5000, 16'hA001);
        send_op(FUNC_ENQ, DSCP_REMARK, 16'hFFFF, 16'hA002);
        send_op(FUNC_ENQ, DSCP_REMARK, 16'd1, 16'hA003);
        send_op(FUNC_ENQ, 6'd63, 16'd5000, 16'hA004);
        send_op(FUNC_ENQ, 6'd5, 16'd8080, 16'hA005);
        send_op(FUNC_PEEK, '0, '0, '0);
        send_op(FUNC_DEQ, '0, '0, '0);
        send_op(FUNC_DEQ, '0, '0, '0);
        // Bands six and seven now hold packets that a count of two hides.
        wait_idle();
        write_reg(CFG_BAND_COUNT, CFG_DAT_W'(4'd1));
        send_op(FUNC_DEQ, '0, '0, '0);
        send_op(FUNC_ENQ, DSCP_EF, '0, 16'hA006);
        send_op(FUNC_DEQ, '0, '0, '0);
        send_op(FUNC_PEEK, '0, '0, '0);
        wait_idle();
        write_reg(CFG_BAND_COUNT, CFG_DAT_W'(4'd15));
        repeat (4) send_op(FUNC_DEQ, '0, '0, '0);
    endtask

    // Fill one band past its depth so that the tail drops, then drain the
    // whole queue.
    task automatic test_full_band();
        logic [DSCP_W-1:0] hot_dscp;
        wait_idle();
        hot_dscp = DSCP_W'($urandom);
        if (hot_dscp == DSCP_REMARK) hot_dscp = DSCP_EF;
        write_reg(CFG_BAND_COUNT, CFG_DAT_W'(4'd8));
        write_reg(CFG_BAND_RULE_0,
                  CFG_DAT_W'(t_band_rule'{valid: 1'b1, dscp: hot_dscp, band: BAND_W'($urandom)}));
        repeat (BAND_DEPTH + 6) send_op(FUNC_ENQ, hot_dscp, PORT_W'($urandom), TAG_W'($urandom));
        send_op(FUNC_PEEK, '0, '0, '0);
        while (queued_total() != 0) send_op(FUNC_DEQ, '0, '0, '0);
        send_op(FUNC_DEQ, '0, '0, '0);
        send_op(FUNC_PEEK, '0, '0, '0);
    endtask

    // Random traffic in phases, each with fresh rules and its own mix of
    // enqueues against dequeues, so bands both fill up and run dry.
    task automatic test_random_traffic(input int phases, input int items_per_phase);
        int enq_pct;
        for (int p = 0; p < phases; p++) begin
            wait_idle();
            randomize_rules();
            case (p % 3)
                0:       enq_pct = 85;
                1:       enq_pct = 50;
                default: enq_pct = 20;
            endcase
            tx_idle_en = ($urandom_range(0, 3) != 0);
            rx_idle_en = ($urandom_range(0, 3) != 0);
            repeat (items_per_phase) send_random_op(enq_pct);
        end
    endtask

    // Final stretch at full rate on both sides.
    task automatic test_back_to_back(input int items);
        wait_idle();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        randomize_rules();
        repeat (items) send_random_op(55);
    endtask

    // Receiver side: random stall bursts while idling is enabled, otherwise
    // always ready.
    always @(posedge i_clk) begin
        if (rx_stall_left != 0) begin
            rx_stall_left <= rx_stall_left - 1;
            m_tready      <= 1'b0;
        end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
            rx_stall_left <= $urandom_range(0, 8);
            m_tready      <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Every result transfer is compared field by field with the oldest
    // prediction. Values are sampled as they stood before the edge.
    always @(posedge i_clk) begin
        t_queue_result got;
        t_queue_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got.ok   = m_tuser[0];
            got.band = m_tdata[BAND_W-1:0];
            got.dscp = m_tdata[BAND_W +: DSCP_W];
            got.tag  = m_tdata[BAND_W + DSCP_W +: TAG_W];
            if (expected_results.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: result with nothing outstanding: ok=%0b band=%0d dscp=%0d tag=%h",
                             $realtime, got.ok, got.band, got.dscp, got.tag);
            end else begin
                want = expected_results.pop_front();
                checked_count++;
                if (got.ok !== want.ok || got.band !== want.band ||
                    got.dscp !== want.dscp || got.tag !== want.tag) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS) begin
                        $display("%0t: result mismatch: expected ok=%0b band=%0d dscp=%0d tag=%h",
                                 $realtime, want.ok, want.band, want.dscp, want.tag);
                        $display("    got ok=%0b band=%0d dscp=%0d tag=%h",
                                 got.ok, got.band, got.dscp, got.tag);
                    end
                end
            end
        end
    end

    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("Timeout with %0d results outstanding", expected_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        band_rule_q[0] = BAND_RULE_0_RST;
        band_rule_q[1] = BAND_RULE_1_RST;
        band_rule_q[2] = BAND_RULE_2_RST;
        port_rule_q[0] = PORT_RULE_0_RST;
        port_rule_q[1] = PORT_RULE_1_RST;
        port_rule_q[2] = PORT_RULE_2_RST;
        band_count_q   = BAND_COUNT_RST;
        for (int b = 0; b < MAX_BANDS; b++) begin
            ring_head[b] = 0;
            ring_tail[b] = 0;
            ring_fill[b] = 0;
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_rule_tables();
        test_full_band();
        test_random_traffic(12, 98);
        test_back_to_back(200);

        // Drain, then give the pipeline time to show any stray transfer.
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            error_count++;
            $display("%0d predicted results never arrived", expected_results.size());
        end

        $display("Ran %0d operations: %0d enqueues stored, %0d dropped at a full band, %0d remarked.",
                 op_count, enq_stored, enq_dropped, remark_count);
        $display("%0d packets served, %0d empty dequeues or peeks, %0d register writes, %0d checked.",
                 served_count, empty_count, cfg_writes, checked_count);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d errors", error_count);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[dscp_strict_priority_queue.f]
hw/rtl/dscpq_pkg.sv
hw/rtl/dscpq_ram.sv
hw/rtl/dscpq_classify.sv
hw/rtl/dscp_strict_priority_queue.sv
hw/rtl/dscpq_checker.sv
tb/dscp_strict_priority_queue_tb.sv
